FILE: rtl/bcs_pkg.sv
// Shared opcodes, command codes and decode types for the bytecode command sequencer.
package bcs_pkg;

    // Instruction opcodes
    localparam logic [7:0] OP_START     = 8'h01;
    localparam logic [7:0] OP_WAIT      = 8'h02;
    localparam logic [7:0] OP_LED_ON    = 8'h44;
    localparam logic [7:0] OP_LED_OFF   = 8'h45;
    localparam logic [7:0] OP_SOUND     = 8'h48;
    localparam logic [7:0] OP_SOUND_OFF = 8'h09;
    localparam logic [7:0] OP_STOP_A    = 8'h60;
    localparam logic [7:0] OP_STOP_B    = 8'h61;
    localparam logic [7:0] OP_FWD       = 8'h62;
    localparam logic [7:0] OP_BACK      = 8'h63;
    localparam logic [7:0] OP_RIGHT     = 8'h64;
    localparam logic [7:0] OP_LEFT      = 8'h65;
    localparam logic [7:0] OP_LOOP_BEG  = 8'hC0;
    localparam logic [7:0] OP_LOOP_END  = 8'hC1;
    localparam logic [7:0] OP_END       = 8'hFF;

    // LED operand selectors
    localparam logic [7:0] LED_SEL_GREEN = 8'h01;
    localparam logic [7:0] LED_SEL_RED   = 8'h02;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PROGRAM_SIZE  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_START_ADDRESS = 1'b1;

    // Field widths
    localparam int OPCODE_BITS = 8;
    localparam int ARG_BITS    = 8;
    localparam int ACT_BITS    = 4;
    localparam int OUT_ADDR_BITS = 16;
    localparam int CFG_DATA_BITS = 16;
    localparam int IN_DATA_BITS  = 16;
    localparam int OUT_DATA_BITS = 32;

    // Robot command codes
    typedef enum logic [ACT_BITS-1:0] {
        ACT_NONE      = 4'd0,
        ACT_WAIT      = 4'd1,
        ACT_GREEN     = 4'd2,
        ACT_RED       = 4'd3,
        ACT_LED_OFF   = 4'd4,
        ACT_SOUND     = 4'd5,
        ACT_SOUND_OFF = 4'd6,
        ACT_STOP      = 4'd7,
        ACT_FWD       = 4'd8,
        ACT_BACK      = 4'd9,
        ACT_RIGHT     = 4'd10,
        ACT_LEFT      = 4'd11
    } act_t;

    // Decoder result handed to the sequencer control
    typedef struct packed {
        act_t                act;
        logic [ARG_BITS-1:0] arg;
        logic                is_start;
        logic                is_loop_beg;
        logic                is_loop_end;
        logic                is_end;
    } dec_t;

endpackage

FILE: rtl/bcs_decode.sv
// Opcode/operand decoder: maps one instruction pair to a command and control flags.
module bcs_decode (
    input  logic [bcs_pkg::OPCODE_BITS-1:0] opcode,
    input  logic [bcs_pkg::ARG_BITS-1:0]    operand,
    output bcs_pkg::dec_t                   dec
);
    import bcs_pkg::*;

    // Command lookup
    always_comb
    begin
        dec             = '0;
        dec.act         = ACT_NONE;
        dec.arg         = '0;
        case (opcode)
            OP_START:     dec.is_start = 1'b1;
            OP_WAIT:
            begin
                dec.act = ACT_WAIT;
                dec.arg = operand;
            end
            OP_LED_ON:
            begin
                if (operand == LED_SEL_GREEN)
                begin
                    dec.act = ACT_GREEN;
                end
                else if (operand == LED_SEL_RED)
                begin
                    dec.act = ACT_RED;
                end
            end
            OP_LED_OFF:   dec.act = ACT_LED_OFF;
            OP_SOUND:
            begin
                dec.act = ACT_SOUND;
                dec.arg = operand;
            end
            OP_SOUND_OFF: dec.act = ACT_SOUND_OFF;
            OP_STOP_A,
            OP_STOP_B:    dec.act = ACT_STOP;
            OP_FWD:
            begin
                dec.act = ACT_FWD;
                dec.arg = operand;
            end
            OP_BACK:
            begin
                dec.act = ACT_BACK;
                dec.arg = operand;
            end
            OP_RIGHT:
            begin
                dec.act = ACT_RIGHT;
                dec.arg = operand;
            end
            OP_LEFT:
            begin
                dec.act = ACT_LEFT;
                dec.arg = operand;
            end
            OP_LOOP_BEG:  dec.is_loop_beg = 1'b1;
            OP_LOOP_END:  dec.is_loop_end = 1'b1;
            OP_END:
            begin
                dec.act    = ACT_STOP;
                dec.is_end = 1'b1;
            end
            default:      dec.act = ACT_NONE;
        endcase
    end

endmodule

FILE: rtl/bytecode_command_sequencer_unit.sv
// Top level of the bytecode command sequencer: state, size check, loop control, result register.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------------------
//  s_*     | in        | s_tvalid/s_tready  | s_tdata: opcode, operand
//  m_*     | out       | m_tvalid/m_tready  | m_tdata: action_code, argument, next_address,
//          |           |                    |          finished
//  cfg_*   | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  One word in, one word out; a word can be accepted every cycle while s_tready is high,
//  and its result is shown from the result register in the cycle after. Decode, size
//  check and loop update sit in one combinational pass feeding that register. s_tready
//  drops only while a held result is not taken. Reset: program_counter = 2,
//  program_size = 65535, loop and status flags clear. cfg_ready is always high.
module bytecode_command_sequencer_unit #(
    parameter int ADDR_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // [7:0] opcode, [15:8] operand
    input  logic [bcs_pkg::IN_DATA_BITS-1:0]     s_tdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [3:0] action_code, [11:4] action_argument, [27:12] next_address,
    // [28] finished, [31:29] zero
    output logic [bcs_pkg::OUT_DATA_BITS-1:0]    m_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bcs_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [bcs_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import bcs_pkg::*;

    localparam int CMP_BITS = (ADDR_BITS + 1 > CFG_DATA_BITS) ? ADDR_BITS + 1 : CFG_DATA_BITS;
    localparam int PAD_BITS = OUT_DATA_BITS - ACT_BITS - ARG_BITS - OUT_ADDR_BITS - 1;
    localparam logic [ADDR_BITS-1:0] PC_RESET = ADDR_BITS'(2);
    localparam logic [ADDR_BITS:0]   PC_STEP  = (ADDR_BITS + 1)'(2);

    // Sequencer state
    logic [ADDR_BITS-1:0]     pc_reg, pc_next;
    logic [ADDR_BITS-1:0]     ret_reg, ret_next;
    logic [ARG_BITS-1:0]      rem_reg, rem_next;
    logic                     loop_active_reg, loop_active_next;
    logic                     start_seen_reg, start_seen_next;
    logic                     done_reg, done_next;
    logic [CFG_DATA_BITS-1:0] size_reg, size_next;

    // Result register
    logic                     out_valid_reg, out_valid_next;
    act_t                     out_act_reg, out_act_next;
    logic [ARG_BITS-1:0]      out_arg_reg, out_arg_next;
    logic [OUT_ADDR_BITS-1:0] out_addr_reg, out_addr_next;
    logic                     out_fin_reg, out_fin_next;

    logic                 s_accept;
    logic                 cfg_accept;
    dec_t                 dec;
    logic [ADDR_BITS:0]   after_wide;
    logic [ADDR_BITS-1:0] after;
    logic                 size_fail;

    assign s_tready   = !out_valid_reg || m_tready;
    assign s_accept   = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;

    bcs_decode u_decode (
        .opcode  (s_tdata[OPCODE_BITS-1:0]),
        .operand (s_tdata[OPCODE_BITS+ARG_BITS-1:OPCODE_BITS]),
        .dec     (dec)
    );

    // Address after the pair, carry kept for the size check
    assign after_wide = {1'b0, pc_reg} + PC_STEP;
    assign after      = after_wide[ADDR_BITS-1:0];
    assign size_fail  = CMP_BITS'(after_wide) > CMP_BITS'(size_reg);

    // Next state and result
    always_comb
    begin
        pc_next          = pc_reg;
        ret_next         = ret_reg;
        rem_next         = rem_reg;
        loop_active_next = loop_active_reg;
        start_seen_next  = start_seen_reg;
        done_next        = done_reg;
        size_next        = size_reg;
        out_act_next     = out_act_reg;
        out_arg_next     = out_arg_reg;
        out_addr_next    = out_addr_reg;
        out_fin_next     = out_fin_reg;
        out_valid_next   = out_valid_reg && !m_tready;

        if (cfg_accept)
        begin
            case (cfg_index)
                CFG_PROGRAM_SIZE:  size_next = cfg_data;
                CFG_START_ADDRESS: pc_next   = ADDR_BITS'(cfg_data);
                default:           size_next = size_reg;
            endcase
        end

        if (s_accept)
        begin
            out_valid_next = 1'b1;
            out_act_next   = ACT_NONE;
            out_arg_next   = '0;
            out_fin_next   = 1'b0;
            if (done_reg)
            begin
                out_fin_next = 1'b1;
            end
            else if (size_fail)
            begin
                done_next    = 1'b1;
                out_act_next = ACT_STOP;
                out_fin_next = 1'b1;
            end
            else if (!start_seen_reg && !dec.is_start)
            begin
                pc_next = after;
            end
            else
            begin
                start_seen_next = 1'b1;
                out_act_next    = dec.act;
                out_arg_next    = dec.arg;
                pc_next         = after;
                if (dec.is_loop_beg)
                begin
                    ret_next         = after;
                    rem_next         = s_tdata[OPCODE_BITS+ARG_BITS-1:OPCODE_BITS];
                    loop_active_next = 1'b1;
                end
                if (dec.is_loop_end)
                begin
                    if (loop_active_reg && (rem_reg != '0))
                    begin
                        pc_next  = ret_reg;
                        rem_next = rem_reg - ARG_BITS'(1);
                    end
                    else
                    begin
                        loop_active_next = 1'b0;
                    end
                end
                if (dec.is_end)
                begin
                    done_next    = 1'b1;
                    out_fin_next = 1'b1;
                    pc_next      = pc_reg;
                end
            end
            out_addr_next = OUT_ADDR_BITS'(pc_next);
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg          <= PC_RESET;
            ret_reg         <= '0;
            rem_reg         <= '0;
            loop_active_reg <= 1'b0;
            start_seen_reg  <= 1'b0;
            done_reg        <= 1'b0;
            size_reg        <= '1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            pc_reg          <= pc_next;
            ret_reg         <= ret_next;
            rem_reg         <= rem_next;
            loop_active_reg <= loop_active_next;
            start_seen_reg  <= start_seen_next;
            done_reg        <= done_next;
            size_reg        <= size_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_act_reg  <= out_act_next;
        out_arg_reg  <= out_arg_next;
        out_addr_reg <= out_addr_next;
        out_fin_reg  <= out_fin_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {PAD_BITS'(0), out_fin_reg, out_addr_reg, out_arg_reg, out_act_reg};

`ifndef SYNTHESIS
    // A finished result is only ever held once the program is marked done
    a_fin_implies_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_fin_reg |-> done_reg)
        else $error("finished result without done flag");

    // A loop can only be opened after the start opcode
    a_loop_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        loop_active_reg |-> start_seen_reg)
        else $error("loop active before start");

    // Once done, every accepted word gives no command and finished
    a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && done_reg |=> out_valid_reg && out_fin_reg && (out_act_reg == ACT_NONE))
        else $error("command issued after finish");
`endif

endmodule

FILE: tb/tb_bytecode_command_sequencer_unit.sv
// Testbench for the bytecode command sequencer: directed table, random programs, self-check.
`timescale 1ns / 100ps

module tb_bytecode_command_sequencer_unit;
    import bcs_pkg::*;

    localparam int ADDR_W     = 16;
    localparam int WATCH_MAX  = 1000;   // cycles with no handshake anywhere
    localparam int HOLD_LEN   = 64;     // receiver hold-off length
    localparam int PHASE_CNT  = 12;
    localparam int PHASE_LEN  = 150;
    localparam int TOP_LEN    = 80;
    localparam int BLOCK_MAX  = 40;     // slack for a loop block running past a phase target

    // Opcodes with no command behind them
    localparam logic [7:0] OP_UNDEF_LO = 8'h00;
    localparam logic [7:0] OP_UNDEF_HI = 8'hFE;

    // Ways the program is brought to its end
    localparam int END_BY_OPCODE = 0;
    localparam int END_BY_SIZE   = 1;
    localparam int END_BY_CARRY  = 2;

    // Program size choice per phase
    localparam int SIZE_TIGHT = 0;
    localparam int SIZE_FULL  = 1;
    localparam int SIZE_RAND  = 2;

    localparam logic ROW_ITEM = 1'b0;
    localparam logic ROW_CFG  = 1'b1;

    // One result word, act in the low bits as on m_tdata
    typedef struct packed {
        logic        fin;
        logic [15:0] addr;
        logic [7:0]  arg;
        act_t        act;
    } cmd_result_t;

    typedef struct packed {
        logic                    is_cfg;
        logic [CFG_IDX_BITS-1:0] reg_idx;
        logic [15:0]             wdata;
        logic [7:0]              opc;
        logic [7:0]              opd;
        logic                    typed;
        cmd_result_t             want;
    } tab_row_t;

    localparam cmd_result_t NO_RES = '0;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic [IN_DATA_BITS-1:0]  s_tdata   = '0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

    // Sequencer shadow state
    logic [ADDR_W-1:0] seq_pc;
    logic [15:0]       loop_ret;
    logic [7:0]        loop_cnt;
    logic              loop_on;
    logic              started;
    logic              halted;
    logic [15:0]       cfg_size;

    cmd_result_t pending_cmds[$];
    cmd_result_t got_cmd;
    cmd_result_t want_cmd;
    int          mismatch_count = 0;
    int          idle_cycles    = 0;

    // Sender/receiver controls; stimulus sets rx_quiet and hold_req with nonblocking assignments
    logic rx_quiet = 1'b0;
    logic hold_req = 1'b0;
    logic hold_ack = 1'b0;
    int   hold_left = 0;
    logic tx_quiet = 1'b0;

    logic [7:0] cmd_ops [12] = '{OP_WAIT, OP_LED_ON, OP_LED_OFF, OP_SOUND, OP_SOUND_OFF,
                                 OP_STOP_A, OP_STOP_B, OP_FWD, OP_BACK, OP_RIGHT, OP_LEFT,
                                 OP_START};

    // Directed part: skipped pairs after reset, size boundary before start, every opcode, a loop
    tab_row_t dir_tab [30] = '{
        '{ROW_ITEM, CFG_PROGRAM_SIZE, 16'h0000, OP_UNDEF_LO, 8'hFF, 1'b1,
          '{1'b0, 16'h0004, 8'h00, ACT_NONE}},
        '{ROW_ITEM, CFG_PROGRAM_SIZE, 16'h0000, OP_END, 8'hFF, 1'b1,
          '{1'b0, 16'h0006, 8'h00, ACT_NONE}},
        '{ROW_ITEM, CFG_PROGRAM_SIZE, 16'h0000, OP_WAIT, 8'h55, 1'b1,
          '{1'b0, 16'h0008, 8'h00, ACT_NONE}},
        '{ROW_CFG,  CFG_START_ADDRESS, 16'h0100, OP_UNDEF_LO, 8'h00, 1'b0, NO_RES},
        '{ROW_CFG,  CFG_PROGRAM_SIZE,  16'h0104, OP_UNDEF_LO, 8'h00, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_PROGRAM_SIZE, 16'h0000, OP_SOUND, 8'hAA, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_PROGRAM_SIZE, 16'h0000, OP_LOOP_BEG, 8'h03, 1'b1,
          '{1'b0, 16'h0104, 8'h00, ACT_NONE}},
        '{ROW_CFG,  CFG_PROGRAM_SIZE,  16'hFFFF, OP_UNDEF_LO, 8'h00, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_PROGRAM_SIZE, 16'h0000, OP_START, 8'hFF, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_PROGRAM_SIZE, 16'h0000, OP_START, 8'h00, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_PROGRAM_SIZE, 16'h0000, OP_WAIT, 8'hFF, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_PROGRAM_SIZE, 16'h0000, OP_LED_ON, LED_SEL_GREEN, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_PROGRAM_SIZE, 16'h0000, OP_LED_ON, LED_SEL_RED, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_PROGRAM_SIZE, 16'h0000, OP_LED_ON, 8'hFF, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_PROGRAM_SIZE, 16'h0000, OP_LED_OFF, 8'hFF, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_PROGRAM_SIZE, 16'h0000, OP_SOUND, 8'h00, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_PROGRAM_SIZE, 16'h0000, OP_SOUND_OFF, 8'h7F, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_PROGRAM_SIZE, 16'h0000, OP_STOP_A, 8'h80, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_PROGRAM_SIZE, 16'h0000, OP_STOP_B, 8'h01, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_PROGRAM_SIZE, 16'h0000, OP_FWD, 8'hFF, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_PROGRAM_SIZE, 16'h0000, OP_BACK, 8'h01, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_PROGRAM_SIZE, 16'h0000, OP_RIGHT, 8'h80, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_PROGRAM_SIZE, 16'h0000, OP_LEFT, 8'h7F, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_PROGRAM_SIZE, 16'h0000, OP_LOOP_END, 8'h05, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_PROGRAM_SIZE, 16'h0000, OP_LOOP_BEG, 8'h01, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_PROGRAM_SIZE, 16'h0000, OP_FWD, 8'h10, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_PROGRAM_SIZE, 16'h0000, OP_LOOP_END, 8'h00, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_PROGRAM_SIZE, 16'h0000, OP_FWD, 8'h10, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_PROGRAM_SIZE, 16'h0000, OP_LOOP_END, 8'h00, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_PROGRAM_SIZE, 16'h0000, OP_UNDEF_HI, 8'h00, 1'b0, NO_RES}
    };

    bytecode_command_sequencer_unit #(
        .ADDR_BITS (ADDR_W)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Decode one fetched pair and advance the shadow sequencer
    function automatic cmd_result_t decode_and_advance(input logic [7:0] opc,
                                                       input logic [7:0] opd);
        cmd_result_t res;
        logic [16:0] nxt;
        res = '0;
        res.act = ACT_NONE;
        if (halted)
        begin
            res.fin  = 1'b1;
            res.addr = seq_pc;
            return res;
        end
        // size check keeps the carry out of the address
        nxt = {1'b0, seq_pc} + 17'd2;
        if (nxt > {1'b0, cfg_size})
        begin
            halted   = 1'b1;
            res.act  = ACT_STOP;
            res.fin  = 1'b1;
            res.addr = seq_pc;
            return res;
        end
        if (!started && opc != OP_START)
        begin
            seq_pc   = nxt[ADDR_W-1:0];
            res.addr = seq_pc;
            return res;
        end
        started = 1'b1;
        case (opc)
            OP_WAIT:      begin res.act = ACT_WAIT;  res.arg = opd; end
            OP_LED_ON:
                if (opd == LED_SEL_GREEN)
                    res.act = ACT_GREEN;
                else if (opd == LED_SEL_RED)
                    res.act = ACT_RED;
            OP_LED_OFF:   res.act = ACT_LED_OFF;
            OP_SOUND:     begin res.act = ACT_SOUND; res.arg = opd; end
            OP_SOUND_OFF: res.act = ACT_SOUND_OFF;
            OP_STOP_A,
            OP_STOP_B:    res.act = ACT_STOP;
            OP_FWD:       begin res.act = ACT_FWD;   res.arg = opd; end
            OP_BACK:      begin res.act = ACT_BACK;  res.arg = opd; end
            OP_RIGHT:     begin res.act = ACT_RIGHT; res.arg = opd; end
            OP_LEFT:      begin res.act = ACT_LEFT;  res.arg = opd; end
            OP_LOOP_BEG:
            begin
                loop_ret = nxt[15:0];
                loop_cnt = opd;
                loop_on  = 1'b1;
            end
            OP_LOOP_END:
                if (loop_on && loop_cnt != 8'd0)
                begin
                    nxt      = {1'b0, loop_ret};
                    loop_cnt = loop_cnt - 8'd1;
                end
                else
                    loop_on = 1'b0;
            OP_END:
            begin
                halted   = 1'b1;
                res.act  = ACT_STOP;
                res.fin  = 1'b1;
                res.addr = seq_pc;
                return res;
            end
            default: ;
        endcase
        seq_pc   = nxt[ADDR_W-1:0];
        res.addr = seq_pc;
        return res;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endtask

    // Offer one pair; the expectation is queued when the word is taken
    task automatic send_word(input logic [7:0] opc, input logic [7:0] opd,
                             input logic typed, input cmd_result_t want);
        int gap;
        cmd_result_t pred;
        gap = 0;
        if (!tx_quiet)
            while ($urandom_range(99) < 36)
                gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {opd, opc};
        do
            @(posedge clk);
        while (!s_tready);
        pred = decode_and_advance(opc, opd);
        pending_cmds.push_back(typed ? want : pred);
    endtask

    // Register write once every result is out
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] val);
        s_tvalid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_PROGRAM_SIZE)
            cfg_size = val;
        else
            seq_pc = val;
        cfg_valid <= 1'b0;
    endtask

    task automatic pick_cmd(output logic [7:0] opc, output logic [7:0] opd);
        opc = cmd_ops[$urandom_range(11)];
        opd = 8'($urandom_range(255));
        if (opc == OP_LED_ON && $urandom_range(2) != 0)
            opd = $urandom_range(1) ? LED_SEL_GREEN : LED_SEL_RED;
    endtask

    // Random program text: commands, loop blocks replayed per pass, open or stray loops, noise
    task automatic run_phase(input int target);
        int sent;
        int pick;
        int reps;
        int blen;
        logic [7:0] bop [4];
        logic [7:0] barg [4];
        logic [7:0] o;
        logic [7:0] a;
        sent = 0;
        while (sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                pick_cmd(o, a);
                send_word(o, a, 1'b0, NO_RES);
                sent++;
            end
            else if (pick < 80)
            begin
                reps = $urandom_range(3);
                blen = $urandom_range(1, 4);
                for (int i = 0; i < blen; i++)
                    pick_cmd(bop[i], barg[i]);
                send_word(OP_LOOP_BEG, 8'(reps), 1'b0, NO_RES);
                for (int r = 0; r <= reps; r++)
                begin
                    for (int i = 0; i < blen; i++)
                        send_word(bop[i], barg[i], 1'b0, NO_RES);
                    send_word(OP_LOOP_END, 8'($urandom_range(255)), 1'b0, NO_RES);
                end
                sent += 1 + (reps + 1) * (blen + 1);
            end
            else if (pick < 90)
            begin
                // stray loop end, or a loop start left open
                o = $urandom_range(1) ? OP_LOOP_END : OP_LOOP_BEG;
                send_word(o, 8'($urandom_range(255)), 1'b0, NO_RES);
                sent++;
            end
            else
            begin
                send_word(8'($urandom_range(254)), 8'($urandom_range(255)), 1'b0, NO_RES);
                sent++;
            end
        end
    endtask

    // Result port ready: random idling, quiet stretch, and one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_ack != hold_req)
        begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_LEN;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= rx_quiet || ($urandom_range(99) >= 36);
    end

    // Result check against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_cmd = m_tdata[28:0];
            if (pending_cmds.size() == 0)
                note_mismatch($sformatf("unexpected word: act=%0d arg=%h addr=%h fin=%b",
                                        got_cmd.act, got_cmd.arg, got_cmd.addr, got_cmd.fin));
            else
            begin
                want_cmd = pending_cmds.pop_front();
                if (got_cmd.act !== want_cmd.act || got_cmd.arg !== want_cmd.arg ||
                    got_cmd.addr !== want_cmd.addr || got_cmd.fin !== want_cmd.fin ||
                    m_tdata[31:29] !== 3'b000)
                    note_mismatch($sformatf(
                    "exp act=%0d arg=%h addr=%h fin=%b got act=%0d arg=%h addr=%h fin=%b pad=%b",
                        want_cmd.act, want_cmd.arg, want_cmd.addr, want_cmd.fin,
                        got_cmd.act, got_cmd.arg, got_cmd.addr, got_cmd.fin, m_tdata[31:29]));
            end
        end
    end

    // Watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCH_MAX)
            begin
                $display("tb_bytecode_command_sequencer_unit: done, errors");
                $finish;
            end
        end
    end

    // Stimulus
    initial
    begin : stim
        int mode;
        int route;
        int span_top;
        logic [15:0] base;
        logic [7:0] o;
        logic [7:0] a;

        // state after reset
        cfg_size  = 16'hFFFF;
        seq_pc    = 16'h0002;
        loop_ret  = '0;
        loop_cnt  = '0;
        loop_on   = 1'b0;
        started   = 1'b0;
        halted    = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[r])
        begin
            if (dir_tab[r].is_cfg == ROW_CFG)
                write_reg(dir_tab[r].reg_idx, dir_tab[r].wdata);
            else
                send_word(dir_tab[r].opc, dir_tab[r].opd, dir_tab[r].typed, dir_tab[r].want);
        end

        // random phases, each with its own address window
        for (int ph = 0; ph < PHASE_CNT; ph++)
        begin
            base = (ph == 0) ? 16'h0000 : 16'($urandom_range(16'h8000));
            mode = (ph == 0) ? SIZE_TIGHT : $urandom_range(2);
            span_top = ((base > loop_ret) ? base : loop_ret) + 2 * (PHASE_LEN + BLOCK_MAX);
            if (span_top > 65535)
                span_top = 65535;
            if (mode == SIZE_FULL)
                span_top = 65535;
            else if (mode == SIZE_RAND)
                span_top = $urandom_range(65535, span_top);
            write_reg(CFG_PROGRAM_SIZE, 16'(span_top));
            write_reg(CFG_START_ADDRESS, base);
            if (ph == 3)
            begin
                // receiver holds off while the sender keeps pushing
                tx_quiet = 1'b1;
                hold_req <= ~hold_req;
            end
            else if (ph == 6)
            begin
                tx_quiet = 1'b1;
                rx_quiet <= 1'b1;
            end
            run_phase(PHASE_LEN);
            if (ph == 6)
                rx_quiet <= 1'b0;
            tx_quiet = 1'b0;
        end

        // top of the address space
        write_reg(CFG_PROGRAM_SIZE, 16'hFFFF);
        write_reg(CFG_START_ADDRESS, 16'hFEC0);
        run_phase(TOP_LEN);

        // finish the program one way or another
        route = $urandom_range(END_BY_CARRY);
        if (route == END_BY_OPCODE)
            send_word(OP_END, 8'($urandom_range(255)), 1'b0, NO_RES);
        else
        begin
            if (route == END_BY_SIZE)
                write_reg(CFG_PROGRAM_SIZE, seq_pc + 16'd1);
            else
            begin
                write_reg(CFG_PROGRAM_SIZE, 16'hFFFF);
                write_reg(CFG_START_ADDRESS, 16'hFFFE);
            end
            pick_cmd(o, a);
            send_word(o, a, 1'b0, NO_RES);
        end

        // after the end nothing acts any more
        send_word(OP_START, 8'h01, 1'b0, NO_RES);
        send_word(OP_END, 8'hFF, 1'b0, NO_RES);
        send_word(OP_LOOP_BEG, 8'h02, 1'b0, NO_RES);
        send_word(OP_LOOP_END, 8'h00, 1'b0, NO_RES);
        run_phase(12);
        write_reg(CFG_PROGRAM_SIZE, 16'h0000);
        write_reg(CFG_START_ADDRESS, 16'hFFFF);
        run_phase(6);

        s_tvalid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (pending_cmds.size() != 0)
            note_mismatch("expected words never arrived");
        if (mismatch_count == 0)
            $display("tb_bytecode_command_sequencer_unit: done, clean");
        else
            $display("tb_bytecode_command_sequencer_unit: done, errors");
        $finish;
    end

endmodule
